// ===== rtl/ipv4hpc_pkg.sv =====
package ipv4hpc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  layer_class;
        logic [7:0]  ip_protocol;
        logic [15:0] transport_offset;
        logic [15:0] total_length;
        logic [2:0]  tunnel_depth;
        logic        ah_present;
        logic        packet_done;
    } out_item_t;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNC     = 4'd1;
    localparam logic [3:0] ST_SHORT_IHL = 4'd2;
    localparam logic [3:0] ST_BAD_VER   = 4'd3;
    localparam logic [3:0] ST_BAD_CSUM  = 4'd4;
    localparam logic [3:0] ST_NESTED_AH = 4'd5;
    localparam logic [3:0] ST_SHORT_AH  = 4'd6;
    localparam logic [3:0] ST_AH_TRUNC  = 4'd7;
    localparam logic [3:0] ST_DEEP      = 4'd8;

    localparam logic [3:0] CL_NONE   = 4'd0;
    localparam logic [3:0] CL_RAW    = 4'd1;
    localparam logic [3:0] CL_TUNNEL = 4'd2;
    localparam logic [3:0] CL_ICMP   = 4'd3;
    localparam logic [3:0] CL_TCP    = 4'd4;
    localparam logic [3:0] CL_UDP    = 4'd5;
    localparam logic [3:0] CL_ESP    = 4'd6;
    localparam logic [3:0] CL_FRAG   = 4'd7;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IPIP = 8'd4;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ESP  = 8'd50;
    localparam logic [7:0] PROTO_AH   = 8'd51;

    localparam logic [15:0] CSUM_GOOD = 16'hffff;

endpackage

// ===== rtl/ipv4hpc_parser.sv =====
module ipv4hpc_parser #(
    parameter int MAX_TUNNEL_DEPTH = 4,
    parameter int ICMP_HDR_BYTES   = 4,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  ipv4hpc_pkg::in_item_t  in_item,
    output logic                   res_valid,
    output ipv4hpc_pkg::out_item_t res_item
);
    import ipv4hpc_pkg::*;

    localparam logic [2:0] PH_IP     = 3'd0;
    localparam logic [2:0] PH_TCP    = 3'd1;
    localparam logic [2:0] PH_FIXED  = 3'd2;
    localparam logic [2:0] PH_AHFIX  = 3'd3;
    localparam logic [2:0] PH_AHBODY = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [15:0] MAX_POS = 16'(MAX_PACKET_BYTES);
    localparam logic [2:0]  MAX_DEP = 3'(MAX_TUNNEL_DEPTH);
    localparam logic [15:0] ICMP_LEN = 16'(ICMP_HDR_BYTES);

    logic [15:0] pos_reg, pos_next, hstart_reg, hstart_next;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  hwords_reg, hwords_next;
    logic [7:0]  proto_reg, proto_next, hbyte_reg, hbyte_next;
    logic [7:0]  scr_reg, scr_next;
    logic [13:0] frag_reg, frag_next;
    logic [15:0] olen_reg, olen_next, rend_reg, rend_next, aend_reg, aend_next;
    logic [15:0] csum_reg, csum_next;
    logic [2:0]  dep_reg, dep_next;
    logic        ahf_reg, ahf_next, ahl_reg, ahl_next, verok_reg, verok_next;
    logic [3:0]  st_reg, st_next, cl_reg, cl_next;

    logic [15:0] rel, here;
    logic [16:0] csum_sum;
    logic [15:0] csum_fold, tcp_len, ah_len17;
    logic [10:0] ah_len;
    logic [7:0]  b;
    logic [7:0]  disp_proto;
    logic [15:0] disp_at;
    logic        do_disp;

    assign b    = in_item.data_byte;
    assign rel  = pos_reg - hstart_reg;
    assign here = pos_reg + 16'd1;
    assign csum_sum  = {1'b0, csum_reg} + {1'b0, hbyte_reg, b};
    assign csum_fold = csum_sum[15:0] + {15'd0, csum_sum[16]};
    assign tcp_len   = {10'd0, scr_reg[3:0], 2'b00};
    assign ah_len    = ({3'b000, scr_reg} + 11'd2) << 2;
    assign ah_len17  = {5'd0, ah_len};

    always_comb
    begin
        pos_next = pos_reg; hstart_next = hstart_reg; phase_next = phase_reg;
        hwords_next = hwords_reg; proto_next = proto_reg; hbyte_next = hbyte_reg;
        scr_next = scr_reg; frag_next = frag_reg; olen_next = olen_reg;
        rend_next = rend_reg; aend_next = aend_reg; csum_next = csum_reg;
        dep_next = dep_reg; ahf_next = ahf_reg; ahl_next = ahl_reg;
        verok_next = verok_reg; st_next = st_reg; cl_next = cl_reg;
        do_disp = 1'b0; disp_proto = proto_reg; disp_at = here;

        if (in_valid && pos_reg < MAX_POS) begin
            pos_next = here;
            unique case (phase_reg)
                PH_IP:
                begin
                    if (rel == 16'd0) begin
                        hwords_next = b[3:0];
                        verok_next  = (b[7:4] == 4'd4);
                    end
                    if (!rel[0]) hbyte_next = b;
                    else         csum_next = csum_fold;
                    if (dep_reg == 3'd0 && rel == 16'd2) olen_next = {b, 8'd0};
                    if (dep_reg == 3'd0 && rel == 16'd3) olen_next = {olen_reg[15:8], b};
                    if (rel == 16'd6) frag_next = {b[5:0], 8'd0};
                    if (rel == 16'd7) frag_next = {frag_reg[13:8], b};
                    if (rel == 16'd9) proto_next = b;
                    if (rel == 16'd19 && hwords_reg < 4'd5) begin
                        st_next = ST_SHORT_IHL; phase_next = PH_DONE;
                    end else if (rel == 16'd19 && !verok_reg) begin
                        st_next = ST_BAD_VER; phase_next = PH_DONE;
                    end else if (rel >= 16'd19
                                 && rel == {10'd0, hwords_reg, 2'b00} - 16'd1) begin
                        aend_next = here;
                        if (csum_fold != CSUM_GOOD) begin
                            st_next = ST_BAD_CSUM; phase_next = PH_DONE;
                        end else if (frag_reg != 14'd0) begin
                            cl_next = CL_FRAG; st_next = ST_OK; phase_next = PH_DONE;
                        end else begin
                            do_disp = 1'b1; disp_proto = proto_reg; disp_at = here;
                        end
                    end
                end
                PH_TCP:
                begin
                    if (rel == 16'd12) scr_next = {4'd0, b[7:4]};
                    if (rel == 16'd19) begin
                        if (tcp_len <= 16'd20) begin
                            aend_next = hstart_reg + tcp_len;
                            cl_next = CL_TCP; st_next = ST_OK; phase_next = PH_DONE;
                        end else begin
                            rend_next = hstart_reg + tcp_len;
                            scr_next = {4'd0, CL_TCP}; phase_next = PH_FIXED;
                        end
                    end
                end
                PH_FIXED:
                begin
                    if (here >= rend_reg) begin
                        aend_next = rend_reg; cl_next = scr_reg[3:0];
                        st_next = ST_OK; phase_next = PH_DONE;
                    end
                end
                PH_AHFIX:
                begin
                    if (rel == 16'd0) hbyte_next = b;
                    if (rel == 16'd1) scr_next = b;
                    if (rel == 16'd11) begin
                        rend_next = hstart_reg + ah_len17;
                        phase_next = PH_AHBODY;
                        if (here >= hstart_reg + ah_len17) begin
                            ahf_next = 1'b1; ahl_next = 1'b1;
                            aend_next = hstart_reg + ah_len17;
                            do_disp = 1'b1; disp_proto = hbyte_reg;
                            disp_at = hstart_reg + ah_len17;
                        end
                    end
                end
                PH_AHBODY:
                begin
                    if (here >= rend_reg) begin
                        ahf_next = 1'b1; ahl_next = 1'b1; aend_next = rend_reg;
                        do_disp = 1'b1; disp_proto = hbyte_reg; disp_at = rend_reg;
                    end
                end
                default: ;
            endcase

            if (do_disp) begin
                priority case (disp_proto)
                    PROTO_ICMP:
                    begin
                        scr_next = {4'd0, CL_ICMP}; rend_next = disp_at + ICMP_LEN;
                        phase_next = PH_FIXED;
                    end
                    PROTO_IPIP:
                    begin
                        cl_next = CL_TUNNEL;
                        if (dep_reg >= MAX_DEP) begin
                            st_next = ST_DEEP; phase_next = PH_DONE;
                        end else begin
                            dep_next = dep_reg + 3'd1; ahl_next = 1'b0;
                            hstart_next = disp_at; csum_next = 16'd0; phase_next = PH_IP;
                        end
                    end
                    PROTO_TCP:
                    begin
                        hstart_next = disp_at; phase_next = PH_TCP;
                    end
                    PROTO_UDP:
                    begin
                        scr_next = {4'd0, CL_UDP}; rend_next = disp_at + 16'd8;
                        phase_next = PH_FIXED;
                    end
                    PROTO_ESP:
                    begin
                        scr_next = {4'd0, CL_ESP}; rend_next = disp_at + 16'd8;
                        phase_next = PH_FIXED;
                    end
                    PROTO_AH:
                    begin
                        if (ahl_next) begin
                            st_next = ST_NESTED_AH; phase_next = PH_DONE;
                        end else begin
                            hstart_next = disp_at; phase_next = PH_AHFIX;
                        end
                    end
                    default:
                    begin
                        cl_next = CL_RAW; st_next = ST_OK; phase_next = PH_DONE;
                    end
                endcase
            end
        end
        // ah short check happens in the AH fixed part
        if (in_valid && pos_reg < MAX_POS && phase_reg == PH_AHFIX && rel == 16'd11
            && ah_len < 11'd12) begin
            st_next = ST_SHORT_AH; phase_next = PH_DONE;
            ahf_next = ahf_reg; ahl_next = ahl_reg; aend_next = aend_reg;
            rend_next = rend_reg; hstart_next = hstart_reg; dep_next = dep_reg;
            cl_next = cl_reg; csum_next = csum_reg; scr_next = scr_reg;
        end
    end

    always_comb
    begin
        res_item.status = (phase_next == PH_DONE)   ? st_next :
                          (phase_next == PH_AHBODY) ? ST_AH_TRUNC : ST_TRUNC;
        res_item.layer_class      = cl_next;
        res_item.ip_protocol      = proto_next;
        res_item.transport_offset = aend_next;
        res_item.total_length     = olen_next;
        res_item.tunnel_depth     = dep_next;
        res_item.ah_present       = ahf_next;
        res_item.packet_done      = 1'b1;
    end
    assign res_valid = in_valid && in_item.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0; hstart_reg <= '0; phase_reg <= PH_IP; hwords_reg <= '0;
            proto_reg <= '0; hbyte_reg <= '0; scr_reg <= '0; frag_reg <= '0;
            olen_reg <= '0; rend_reg <= '0; aend_reg <= '0; csum_reg <= '0;
            dep_reg <= '0; ahf_reg <= 1'b0; ahl_reg <= 1'b0; verok_reg <= 1'b0;
            st_reg <= '0; cl_reg <= '0;
        end else if (res_valid) begin
            pos_reg <= '0; hstart_reg <= '0; phase_reg <= PH_IP; hwords_reg <= '0;
            proto_reg <= '0; hbyte_reg <= '0; scr_reg <= '0; frag_reg <= '0;
            olen_reg <= '0; rend_reg <= '0; aend_reg <= '0; csum_reg <= '0;
            dep_reg <= '0; ahf_reg <= 1'b0; ahl_reg <= 1'b0; verok_reg <= 1'b0;
            st_reg <= '0; cl_reg <= '0;
        end else begin
            pos_reg <= pos_next; hstart_reg <= hstart_next; phase_reg <= phase_next;
            hwords_reg <= hwords_next; proto_reg <= proto_next; hbyte_reg <= hbyte_next;
            scr_reg <= scr_next; frag_reg <= frag_next; olen_reg <= olen_next;
            rend_reg <= rend_next; aend_reg <= aend_next; csum_reg <= csum_next;
            dep_reg <= dep_next; ahf_reg <= ahf_next; ahl_reg <= ahl_next;
            verok_reg <= verok_next; st_reg <= st_next; cl_reg <= cl_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_DONE)
        else $error("phase out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        dep_reg <= MAX_DEP)
        else $error("tunnel depth beyond limit");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (pos_reg == 16'd0 && phase_reg == PH_IP))
        else $error("no restart after packet");

endmodule

// ===== rtl/ipv4hpc_res_fifo.sv =====
module ipv4hpc_res_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  ipv4hpc_pkg::out_item_t wr_item,
    input  logic                   rd_en,
    output ipv4hpc_pkg::out_item_t rd_item,
    output logic                   empty,
    output logic                   full
);
    import ipv4hpc_pkg::*;

    out_item_t   mem_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        wp_reg, rp_reg;

    assign empty   = (cnt_reg == 2'd0);
    assign full    = (cnt_reg == 2'd2);
    assign rd_item = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0; wp_reg <= 1'b0; rp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !(wr_en && full && !rd_en))
        else $error("write to full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(rd_en && empty))
        else $error("read from empty queue");

endmodule

// ===== rtl/ipv4_header_parser_classifier.sv =====
// IPv4 header parser/classifier: one packet byte per request, last_byte marks the
// packet end; one result per packet on that byte. Steady rate is one byte a cycle
// while full is low: the parser front updates its registers once per byte, and a
// two-entry result queue decouples the back so one result waiting on pop does not
// stall bytes. full rises only when two results are still unread.
module ipv4_header_parser_classifier #(
    parameter int MAX_TUNNEL_DEPTH = 4,
    parameter int ICMP_HDR_BYTES   = 4,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  ipv4hpc_pkg::in_item_t  in_data,
    input  logic                   pop,
    output logic                   empty,
    output ipv4hpc_pkg::out_item_t out_data
);
    import ipv4hpc_pkg::*;

    logic      acc, rv, q_full;
    out_item_t ri;

    // a byte is taken only when the queue can hold its possible result
    assign full = q_full;
    assign acc  = push && !q_full;

    ipv4hpc_parser #(
        .MAX_TUNNEL_DEPTH(MAX_TUNNEL_DEPTH),
        .ICMP_HDR_BYTES(ICMP_HDR_BYTES),
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_item(in_data),
        .res_valid(rv), .res_item(ri)
    );

    ipv4hpc_res_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_en(rv), .wr_item(ri),
        .rd_en(pop && !empty), .rd_item(out_data), .empty(empty), .full(q_full)
    );

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4hpc_pkg::*;

    localparam int MAX_DEPTH  = 4;
    localparam int ICMP_BYTES = 4;
    localparam int PKT_LIMIT  = 256;

    // parser phases of the predictor
    typedef enum logic [2:0] {
        PH_IP, PH_TCP, PH_FIXED, PH_AHFIX, PH_AHBODY, PH_DONE
    } parse_phase_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_data;
    logic      pop;
    logic      empty;
    out_item_t out_data;

    ipv4_header_parser_classifier #(
        .MAX_TUNNEL_DEPTH(MAX_DEPTH),
        .ICMP_HDR_BYTES(ICMP_BYTES),
        .MAX_PACKET_BYTES(PKT_LIMIT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_data(in_data),
        .pop(pop),
        .empty(empty),
        .out_data(out_data)
    );

    // bytes waiting to be offered, packet under construction, expected verdicts
    in_item_t    byte_q[$];
    logic [7:0]  pkt[$];
    out_item_t   verdict_q[$];

    int          bytes_in;
    int          packets_done;
    int          mismatches;
    int          gen_bytes;
    bit          taken;
    bit          hold_done;
    int          hold_left;
    bit [15:0]   status_seen;
    bit [15:0]   class_seen;

    // predictor state
    parse_phase_t phase;
    int unsigned  pos, hdr_start, hdr_words, proto, frag, outer_len, csum;
    int unsigned  hi_byte, need_end, depth, ah_seen, acc_end, scratch;
    int unsigned  ah_level, ver_ok;
    logic [3:0]   st_latch, cls_latch;

    always #10 clk = ~clk;

    task automatic clear_parser();
        phase = PH_IP;
        pos = 0; hdr_start = 0; hdr_words = 0; proto = 0; frag = 0;
        outer_len = 0; csum = 0; hi_byte = 0; need_end = 0; depth = 0;
        ah_seen = 0; acc_end = 0; scratch = 0; ah_level = 0; ver_ok = 0;
        st_latch = ST_OK; cls_latch = CL_NONE;
    endtask

    task automatic finish_with(logic [3:0] st);
        st_latch = st;
        phase = PH_DONE;
    endtask

    // choose the next layer from a protocol number, header starting at byte at
    task automatic dispatch(int unsigned p, int unsigned at);
        case (p[7:0])
            PROTO_ICMP:
            begin
                scratch = CL_ICMP; need_end = at + ICMP_BYTES; phase = PH_FIXED;
            end
            PROTO_IPIP:
            begin
                cls_latch = CL_TUNNEL;
                if (depth >= MAX_DEPTH)
                begin
                    finish_with(ST_DEEP);
                end
                else
                begin
                    depth++;
                    ah_level = 0;
                    hdr_start = at;
                    csum = 0;
                    phase = PH_IP;
                end
            end
            PROTO_TCP:
            begin
                hdr_start = at; phase = PH_TCP;
            end
            PROTO_UDP:
            begin
                scratch = CL_UDP; need_end = at + 8; phase = PH_FIXED;
            end
            PROTO_ESP:
            begin
                scratch = CL_ESP; need_end = at + 8; phase = PH_FIXED;
            end
            PROTO_AH:
            begin
                if (ah_level != 0)
                begin
                    finish_with(ST_NESTED_AH);
                end
                else
                begin
                    hdr_start = at; phase = PH_AHFIX;
                end
            end
            default:
            begin
                cls_latch = CL_RAW;
                finish_with(ST_OK);
            end
        endcase
    endtask

    task automatic accept_ah();
        ah_seen = 1;
        ah_level = 1;
        acc_end = need_end;
        dispatch(hi_byte, need_end);
    endtask

    // advance the parser by one accepted byte, queue a verdict on the last one
    task automatic track_byte(in_item_t it);
        int unsigned rel, here, len, b;
        bit          stop;
        out_item_t   r;
        b = it.data_byte;
        stop = 0;
        if (pos < PKT_LIMIT)
        begin
            rel = pos - hdr_start;
            here = pos + 1;
            case (phase)
                PH_IP:
                begin
                    if (rel == 0)
                    begin
                        hdr_words = b & 15;
                        ver_ok = ((b >> 4) == 4) ? 1 : 0;
                    end
                    if ((rel & 1) == 0)
                    begin
                        hi_byte = b;
                    end
                    else
                    begin
                        csum = csum + ((hi_byte << 8) | b);
                        csum = (csum & 16'hffff) + (csum >> 16);
                    end
                    if (depth == 0 && rel == 2) outer_len = b << 8;
                    if (depth == 0 && rel == 3) outer_len = outer_len | b;
                    if (rel == 6) frag = (b & 8'h3f) << 8;
                    if (rel == 7) frag = frag | b;
                    if (rel == 9) proto = b;
                    if (rel == 19)
                    begin
                        if (hdr_words < 5)
                        begin
                            finish_with(ST_SHORT_IHL); stop = 1;
                        end
                        else if (ver_ok == 0)
                        begin
                            finish_with(ST_BAD_VER); stop = 1;
                        end
                    end
                    if (!stop && rel >= 19 && rel == hdr_words * 4 - 1)
                    begin
                        acc_end = here;
                        if (csum != CSUM_GOOD)
                        begin
                            finish_with(ST_BAD_CSUM);
                        end
                        else if (frag != 0)
                        begin
                            cls_latch = CL_FRAG;
                            finish_with(ST_OK);
                        end
                        else
                        begin
                            dispatch(proto, here);
                        end
                    end
                end
                PH_TCP:
                begin
                    if (rel == 12) scratch = b >> 4;
                    if (rel == 19)
                    begin
                        len = scratch * 4;
                        if (len <= 20)
                        begin
                            acc_end = hdr_start + len;
                            cls_latch = CL_TCP;
                            finish_with(ST_OK);
                        end
                        else
                        begin
                            need_end = hdr_start + len;
                            scratch = CL_TCP;
                            phase = PH_FIXED;
                        end
                    end
                end
                PH_FIXED:
                begin
                    if (here >= need_end)
                    begin
                        acc_end = need_end;
                        cls_latch = scratch[3:0];
                        finish_with(ST_OK);
                    end
                end
                PH_AHFIX:
                begin
                    if (rel == 0) hi_byte = b;
                    if (rel == 1) scratch = b;
                    if (rel == 11)
                    begin
                        len = (scratch + 2) * 4;
                        if (len < 12)
                        begin
                            finish_with(ST_SHORT_AH);
                        end
                        else
                        begin
                            need_end = hdr_start + len;
                            phase = PH_AHBODY;
                            if (here >= need_end) accept_ah();
                        end
                    end
                end
                PH_AHBODY:
                begin
                    if (here >= need_end) accept_ah();
                end
                default:
                begin
                end
            endcase
            pos++;
        end
        if (it.last_byte)
        begin
            if (phase == PH_DONE)
                r.status = st_latch;
            else if (phase == PH_AHBODY)
                r.status = ST_AH_TRUNC;
            else
                r.status = ST_TRUNC;
            r.layer_class      = cls_latch;
            r.ip_protocol      = proto[7:0];
            r.transport_offset = acc_end[15:0];
            r.total_length     = outer_len[15:0];
            r.tunnel_depth     = depth[2:0];
            r.ah_present       = ah_seen[0];
            r.packet_done      = 1'b1;
            verdict_q.push_back(r);
            clear_parser();
        end
    endtask

    // ---------------------------------------------------------------
    // packet building
    // ---------------------------------------------------------------

    // ipv4 header with a correct checksum unless bad is set
    task automatic add_ip(logic [3:0] ver, logic [3:0] ihl, logic [13:0] fo,
                          logic [7:0] p, bit bad);
        logic [7:0]  h[$];
        int          n;
        int unsigned s;
        logic [15:0] c;
        n = (ihl < 5) ? 20 : ihl * 4;
        for (int i = 0; i < n; i++) h.push_back(8'($urandom_range(255, 0)));
        h[0] = {ver, ihl};
        h[6] = {h[6][7:6], fo[13:8]};
        h[7] = fo[7:0];
        h[9] = p;
        h[10] = 8'h00;
        h[11] = 8'h00;
        s = 0;
        for (int i = 0; i < n; i += 2)
        begin
            s = s + {h[i], h[i + 1]};
            s = (s & 16'hffff) + (s >> 16);
        end
        c = ~s[15:0];
        if (bad) c = c ^ 16'h0100;
        h[10] = c[15:8];
        h[11] = c[7:0];
        foreach (h[i]) pkt.push_back(h[i]);
    endtask

    // ipv4 header with mostly sane random fields
    task automatic add_rand_ip(logic [7:0] p);
        logic [3:0]  ver, ihl;
        logic [13:0] fo;
        ver = ($urandom_range(99, 0) < 95) ? 4'd4 : 4'($urandom_range(15, 0));
        ihl = ($urandom_range(99, 0) < 75) ? 4'd5 : 4'($urandom_range(15, 0));
        fo  = ($urandom_range(99, 0) < 88) ? 14'd0 : 14'($urandom_range(16383, 0));
        add_ip(ver, ihl, fo, p, $urandom_range(99, 0) < 5);
    endtask

    task automatic add_ah(logic [7:0] next, logic [7:0] ahl);
        int n;
        n = (ahl + 2) * 4;
        if (n < 12) n = 12;
        pkt.push_back(next);
        pkt.push_back(ahl);
        for (int i = 2; i < n; i++) pkt.push_back(8'($urandom_range(255, 0)));
    endtask

    task automatic add_l4(logic [7:0] p, logic [3:0] doff);
        int n;
        case (p)
            PROTO_ICMP: n = $urandom_range(8, 4);
            PROTO_TCP:  n = (doff * 4 > 20) ? doff * 4 : 20;
            PROTO_UDP:  n = 8;
            PROTO_ESP:  n = 8;
            default:    n = $urandom_range(8, 0);
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (p == PROTO_TCP && i == 12)
                pkt.push_back({doff, 4'($urandom_range(15, 0))});
            else
                pkt.push_back(8'($urandom_range(255, 0)));
        end
    endtask

    // hand the first keep bytes of the built packet to the driver
    task automatic ship(int keep);
        in_item_t it;
        if (keep > pkt.size()) keep = pkt.size();
        if (keep < 1) keep = 1;
        if (pkt.size() == 0) pkt.push_back(8'($urandom_range(255, 0)));
        for (int i = 0; i < keep; i++)
        begin
            it.data_byte = pkt[i];
            it.last_byte = (i == keep - 1);
            byte_q.push_back(it);
        end
        gen_bytes += keep;
        pkt.delete();
    endtask

    function automatic logic [7:0] pick_l4();
        logic [7:0] p;
        case ($urandom_range(4, 0))
            0: p = PROTO_ICMP;
            1: p = PROTO_TCP;
            2: p = PROTO_UDP;
            3: p = PROTO_ESP;
            default:
            begin
                p = 8'($urandom_range(255, 0));
                if (p == PROTO_IPIP || p == PROTO_AH) p = 8'd2;
            end
        endcase
        return p;
    endfunction

    task automatic rand_packet();
        int         layers, r;
        logic [7:0] p;
        bit         use_ah, nest_ah;
        r = $urandom_range(99, 0);
        if (r < 8)
        begin
            // pure noise
            r = $urandom_range(30, 1);
            for (int i = 0; i < r; i++) pkt.push_back(8'($urandom_range(255, 0)));
            ship(r);
            return;
        end
        layers = ($urandom_range(99, 0) < 20) ? $urandom_range(5, 1) : 0;
        for (int i = 0; i < layers; i++) add_rand_ip(PROTO_IPIP);
        p = pick_l4();
        use_ah = $urandom_range(99, 0) < 20;
        nest_ah = use_ah && $urandom_range(99, 0) < 15;
        add_rand_ip(use_ah ? PROTO_AH : p);
        if (use_ah)
        begin
            add_ah(nest_ah ? PROTO_AH : p, $urandom_range(99, 0) < 10 ? 8'd0
                   : 8'($urandom_range(4, 1)));
            if (nest_ah) add_ah(p, 8'd1);
        end
        add_l4(p, 4'($urandom_range(15, 0)));
        r = $urandom_range(6, 0);
        for (int i = 0; i < r; i++) pkt.push_back(8'($urandom_range(255, 0)));
        // occasional corruption or early cut
        if ($urandom_range(99, 0) < 5)
        begin
            r = $urandom_range(pkt.size() - 1, 0);
            pkt[r] = pkt[r] ^ (8'h01 << $urandom_range(7, 0));
        end
        if ($urandom_range(99, 0) < 12)
            ship($urandom_range(pkt.size(), 1));
        else
            ship(pkt.size());
    endtask

    // ---------------------------------------------------------------
    // reset, driver, monitor
    // ---------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // sampling side: record the accepted request, check the accepted result
    always @(posedge clk)
    begin
        out_item_t want;
        taken = 1'b0;
        if (rst_n && push && !full)
        begin
            taken = 1'b1;
            track_byte(in_data);
            void'(byte_q.pop_front());
            bytes_in++;
        end
        if (rst_n && pop && !empty)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result with no packet pending: %p", out_data);
                mismatches++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    mismatches++;
                end
                if (out_data.layer_class !== want.layer_class)
                begin
                    $error("layer_class: expected %0d, got %0d",
                           want.layer_class, out_data.layer_class);
                    mismatches++;
                end
                if (out_data.ip_protocol !== want.ip_protocol)
                begin
                    $error("ip_protocol: expected %0d, got %0d",
                           want.ip_protocol, out_data.ip_protocol);
                    mismatches++;
                end
                if (out_data.transport_offset !== want.transport_offset)
                begin
                    $error("transport_offset: expected %0d, got %0d",
                           want.transport_offset, out_data.transport_offset);
                    mismatches++;
                end
                if (out_data.total_length !== want.total_length)
                begin
                    $error("total_length: expected %0d, got %0d",
                           want.total_length, out_data.total_length);
                    mismatches++;
                end
                if (out_data.tunnel_depth !== want.tunnel_depth)
                begin
                    $error("tunnel_depth: expected %0d, got %0d",
                           want.tunnel_depth, out_data.tunnel_depth);
                    mismatches++;
                end
                if (out_data.ah_present !== want.ah_present)
                begin
                    $error("ah_present: expected %0d, got %0d",
                           want.ah_present, out_data.ah_present);
                    mismatches++;
                end
                if (out_data.packet_done !== want.packet_done)
                begin
                    $error("packet_done: expected %0d, got %0d",
                           want.packet_done, out_data.packet_done);
                    mismatches++;
                end
                status_seen[want.status] = 1'b1;
                class_seen[want.layer_class] = 1'b1;
                packets_done++;
            end
        end
    end

    // request side: hold an unaccepted request, otherwise offer the next byte
    // unless idling; no idling at all inside a window of accepted bytes
    always @(negedge clk)
    begin
        bit quiet;
        quiet = (bytes_in >= 700 && bytes_in < 1000);
        if (rst_n)
        begin
            if (push && !taken)
            begin
                // keep offering the same request
            end
            else if (byte_q.size() > 0 && (quiet || $urandom_range(99, 0) >= 36))
            begin
                push <= 1'b1;
                in_data <= byte_q[0];
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // result side: random stalls, one long hold-off to back up the block
    always @(negedge clk)
    begin
        bit quiet;
        quiet = (bytes_in >= 700 && bytes_in < 1000);
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!hold_done && packets_done >= 30)
            begin
                hold_done = 1'b1;
                hold_left = 400;
                pop <= 1'b0;
            end
            else
            begin
                pop <= quiet || ($urandom_range(99, 0) >= 36);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------

    initial
    begin
        int target;
        bytes_in = 0; packets_done = 0; mismatches = 0; gen_bytes = 0;
        hold_done = 0; hold_left = 0; taken = 0;
        status_seen = '0; class_seen = '0;
        clear_parser();

        // directed: every class, every failure status, field extremes
        add_ip(4, 5, 0, PROTO_UDP, 0);  add_l4(PROTO_UDP, 0);  ship(pkt.size());
        add_ip(4, 5, 0, PROTO_ICMP, 0); add_l4(PROTO_ICMP, 0); ship(pkt.size());
        add_ip(4, 5, 0, PROTO_TCP, 0);  add_l4(PROTO_TCP, 5);  ship(pkt.size());
        add_ip(4, 5, 0, PROTO_TCP, 0);  add_l4(PROTO_TCP, 15); ship(pkt.size());
        add_ip(4, 5, 0, PROTO_TCP, 0);  add_l4(PROTO_TCP, 0);  ship(pkt.size());
        add_ip(4, 5, 0, PROTO_ESP, 0);  add_l4(PROTO_ESP, 0);  ship(pkt.size());
        add_ip(4, 5, 0, 8'd2, 0);       add_l4(8'd2, 0);       ship(pkt.size());
        add_ip(4, 5, 0, 8'd255, 0);     add_l4(8'd255, 0);     ship(pkt.size());
        // short ihl, zero ihl, wrong version, bad checksum
        add_ip(4, 4, 0, PROTO_UDP, 0);  add_l4(PROTO_UDP, 0);  ship(pkt.size());
        add_ip(4, 0, 0, PROTO_UDP, 0);  ship(pkt.size());
        add_ip(6, 5, 0, PROTO_UDP, 0);  add_l4(PROTO_UDP, 0);  ship(pkt.size());
        add_ip(4, 5, 0, PROTO_UDP, 1);  add_l4(PROTO_UDP, 0);  ship(pkt.size());
        // fragments: more-fragments only, all offset bits and flag
        add_ip(4, 5, 14'h2000, PROTO_UDP, 0); ship(pkt.size());
        add_ip(4, 5, 14'h3fff, PROTO_TCP, 0); ship(pkt.size());
        // authentication header: normal, short, nested, cut inside the body
        add_ip(4, 5, 0, PROTO_AH, 0); add_ah(PROTO_UDP, 1); add_l4(PROTO_UDP, 0);
        ship(pkt.size());
        add_ip(4, 5, 0, PROTO_AH, 0); add_ah(PROTO_UDP, 0); ship(pkt.size());
        add_ip(4, 5, 0, PROTO_AH, 0); add_ah(PROTO_AH, 1); add_ah(PROTO_UDP, 1);
        ship(pkt.size());
        add_ip(4, 5, 0, PROTO_AH, 0); add_ah(PROTO_UDP, 4); ship(36);
        // largest AH length, cut just past its fixed part
        add_ip(4, 5, 0, PROTO_AH, 0); add_ah(PROTO_ESP, 255); add_l4(PROTO_ESP, 0);
        ship(40);
        // a tunnel resets the authentication level
        add_ip(4, 5, 0, PROTO_AH, 0); add_ah(PROTO_IPIP, 1);
        add_ip(4, 5, 0, PROTO_AH, 0); add_ah(PROTO_TCP, 1); add_l4(PROTO_TCP, 6);
        ship(pkt.size());
        // tunnels: one level, then one level too many
        add_ip(4, 5, 0, PROTO_IPIP, 0); add_ip(4, 5, 0, PROTO_TCP, 0);
        add_l4(PROTO_TCP, 5); ship(pkt.size());
        for (int i = 0; i <= MAX_DEPTH; i++) add_ip(4, 5, 0, PROTO_IPIP, 0);
        ship(pkt.size());
        // largest header, all-ones first byte, truncations
        add_ip(4, 15, 0, PROTO_UDP, 0); add_l4(PROTO_UDP, 0); ship(pkt.size());
        add_ip(15, 15, 14'h3fff, 8'hff, 0); ship(pkt.size());
        add_ip(4, 5, 0, PROTO_UDP, 0); ship(10);
        pkt.push_back(8'h45); ship(1);
        // bytes beyond the parse window
        add_ip(4, 5, 0, PROTO_UDP, 0); add_l4(PROTO_UDP, 0);
        while (pkt.size() < PKT_LIMIT + 5) pkt.push_back(8'($urandom_range(255, 0)));
        ship(pkt.size());

        // sender pause until the block has drained
        while (byte_q.size() != 0 || verdict_q.size() != 0) @(posedge clk);

        target = 1650;
        while (gen_bytes < target) rand_packet();

        while (byte_q.size() != 0 || verdict_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("checked %0d packets from %0d bytes, %0d mismatches",
                 packets_done, bytes_in, mismatches);
        $display("status codes seen %b, layer classes seen %b",
                 status_seen[8:0], class_seen[7:0]);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d packets still expected", verdict_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ipv4hpc_pkg.sv
rtl/ipv4hpc_parser.sv
rtl/ipv4hpc_res_fifo.sv
rtl/ipv4_header_parser_classifier.sv
test/testbench.sv
